>>> design/dpss_pkg.sv
`timescale 1ns / 1ps

package dpss_pkg;

    localparam int unsigned SW_W    = 16;
    localparam int unsigned CW_W    = 16;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 24;

    typedef enum logic [STATE_W-1:0] {
        ST_NOTREADY   = 3'd0,
        ST_DISABLED   = 3'd1,
        ST_READY      = 3'd2,
        ST_SWITCHEDON = 3'd3,
        ST_OPENABLED  = 3'd4,
        ST_QUICKSTOP  = 3'd5,
        ST_FAULTREACT = 3'd6,
        ST_FAULT      = 3'd7
    } t_drive_state;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_SHUTDOWN    = 3'd1,
        CMD_SWITCH_ON   = 3'd2,
        CMD_DIS_VOLTAGE = 3'd3,
        CMD_QUICK_STOP  = 3'd4,
        CMD_ENABLE_OP   = 3'd5,
        CMD_FAULT_RESET = 3'd6
    } t_cmd;

    localparam logic [CW_W-1:0] CW_SWITCH_ON  = 16'h0001;
    localparam logic [CW_W-1:0] CW_EN_VOLTAGE = 16'h0002;
    localparam logic [CW_W-1:0] CW_QUICK_STOP = 16'h0004;
    localparam logic [CW_W-1:0] CW_EN_OP      = 16'h0008;
    localparam logic [CW_W-1:0] CW_FAULT_RST  = 16'h0080;

    localparam logic [7:0] SW_MASK_A = 8'h4F;
    localparam logic [7:0] SW_MASK_B = 8'h6F;
    localparam logic [7:0] SW_NOTREADY   = 8'h00;
    localparam logic [7:0] SW_DISABLED   = 8'h40;
    localparam logic [7:0] SW_FAULTREACT = 8'h0F;
    localparam logic [7:0] SW_FAULT      = 8'h08;
    localparam logic [7:0] SW_READY      = 8'h21;
    localparam logic [7:0] SW_SWITCHEDON = 8'h23;
    localparam logic [7:0] SW_OPENABLED  = 8'h27;
    localparam logic [7:0] SW_QUICKSTOP  = 8'h07;

    // Only the low byte of the statusword carries state bits.
    function automatic t_drive_state decode_state(input logic [SW_W-1:0] sw);
        logic [7:0]   lo;
        t_drive_state st;
        lo = sw[7:0];
        case (lo & SW_MASK_A)
            SW_NOTREADY:   st = ST_NOTREADY;
            SW_DISABLED:   st = ST_DISABLED;
            SW_FAULTREACT: st = ST_FAULTREACT;
            SW_FAULT:      st = ST_FAULT;
            default: begin
                case (lo & SW_MASK_B)
                    SW_READY:      st = ST_READY;
                    SW_SWITCHEDON: st = ST_SWITCHEDON;
                    SW_OPENABLED:  st = ST_OPENABLED;
                    SW_QUICKSTOP:  st = ST_QUICKSTOP;
                    default:       st = ST_NOTREADY;
                endcase
            end
        endcase
        return st;
    endfunction

    function automatic t_cmd select_cmd(input t_drive_state cur,
                                        input logic [STATE_W-1:0] tgt_raw,
                                        input logic skip);
        t_drive_state tgt;
        logic         in_chain;
        t_cmd         cmd;
        in_chain = (cur == ST_DISABLED) || (cur == ST_READY) ||
                   (cur == ST_SWITCHEDON) || (cur == ST_OPENABLED);
        // Targets off the four-state chain fall back to disabled.
        if ((tgt_raw < 3'(ST_DISABLED)) || (tgt_raw > 3'(ST_OPENABLED))) begin
            tgt = ST_DISABLED;
        end else begin
            tgt = t_drive_state'(tgt_raw);
        end
        cmd = CMD_NONE;
        if (cur == ST_FAULT) begin
            cmd = CMD_FAULT_RESET;
        end else if (in_chain && (cur < tgt)) begin
            case (cur)
                ST_DISABLED: cmd = CMD_SHUTDOWN;
                ST_READY:    cmd = CMD_SWITCH_ON;
                default:     cmd = CMD_ENABLE_OP;
            endcase
        end else if (in_chain && (cur > tgt)) begin
            case (cur)
                ST_OPENABLED: begin
                    if (skip && (tgt == ST_SWITCHEDON)) cmd = CMD_SWITCH_ON;
                    else if (skip && (tgt == ST_READY)) cmd = CMD_SHUTDOWN;
                    else if (skip && (tgt == ST_DISABLED)) cmd = CMD_DIS_VOLTAGE;
                    else cmd = CMD_QUICK_STOP;
                end
                ST_SWITCHEDON: begin
                    cmd = (skip && (tgt == ST_DISABLED)) ? CMD_DIS_VOLTAGE : CMD_SHUTDOWN;
                end
                default: cmd = CMD_DIS_VOLTAGE;
            endcase
        end else if (skip && (cur == ST_QUICKSTOP) && (tgt == ST_DISABLED)) begin
            cmd = CMD_DIS_VOLTAGE;
        end
        return cmd;
    endfunction

    function automatic logic [CW_W-1:0] apply_cmd(input t_cmd cmd,
                                                  input logic [CW_W-1:0] cw);
        logic [CW_W-1:0] nw;
        case (cmd)
            CMD_SHUTDOWN:
                nw = (cw & ~(CW_FAULT_RST | CW_SWITCH_ON)) | CW_QUICK_STOP | CW_EN_VOLTAGE;
            CMD_SWITCH_ON:
                nw = (cw & ~(CW_FAULT_RST | CW_EN_OP)) | CW_QUICK_STOP | CW_EN_VOLTAGE
                     | CW_SWITCH_ON;
            CMD_DIS_VOLTAGE:
                nw = cw & ~(CW_FAULT_RST | CW_EN_VOLTAGE);
            CMD_QUICK_STOP:
                nw = (cw & ~(CW_FAULT_RST | CW_QUICK_STOP)) | CW_EN_VOLTAGE;
            CMD_ENABLE_OP:
                nw = (cw & ~CW_FAULT_RST) | CW_EN_OP | CW_QUICK_STOP | CW_EN_VOLTAGE
                     | CW_SWITCH_ON;
            CMD_FAULT_RESET:
                nw = cw | CW_FAULT_RST;
            default:
                nw = cw;
        endcase
        return nw;
    endfunction

endpackage

>>> design/drive_profile_state_stepper.sv
`timescale 1ns / 1ps
// Each accepted beat goes via the input register, then the result register, to m_axis.
// Throughput: one beat per cycle unless the master stalls; input and result registers
// each refill in the cycle they drain, with the held controlword updated on that move.
// Reset (i_rst_n low, synchronous): both stages empty, held controlword and
// skip_enable cleared to zero.
module drive_profile_state_stepper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: skip_enable
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] status_word, [18:16] wanted_state, [23:19] zero
    input  logic [dpss_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] control_word, [18:16] drive_state, [23:19] zero
    output logic [dpss_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import dpss_pkg::*;

    logic                r_skip;
    logic                r_in_valid;
    logic [SW_W-1:0]     r_in_sw;
    logic [STATE_W-1:0]  r_in_tgt;
    logic                r_out_valid;
    logic [CW_W-1:0]     r_out_cw;
    t_drive_state        r_out_state;
    logic [CW_W-1:0]     r_held_cw;

    logic                s_accept;
    logic                move;
    t_drive_state        cur_state;
    t_cmd                cmd;
    logic [CW_W-1:0]     n_held_cw;

    assign o_cfg_ready = 1'b1;

    // Advance the input stage whenever the result register is empty or draining.
    assign move            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || move;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        cur_state = decode_state(r_in_sw);
        cmd       = select_cmd(cur_state, r_in_tgt, r_skip);
        n_held_cw = apply_cmd(cmd, r_held_cw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held_cw   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_skip <= i_cfg_data;
            end
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_held_cw   <= n_held_cw;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_sw  <= i_s_axis_tdata[SW_W-1:0];
            r_in_tgt <= i_s_axis_tdata[SW_W +: STATE_W];
        end
        if (move) begin
            r_out_cw    <= n_held_cw;
            r_out_state <= cur_state;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - CW_W - STATE_W){1'b0}}, r_out_state, r_out_cw};

endmodule

>>> tb/tb_drive_profile_state_stepper.sv
`timescale 1ns / 1ps

module tb_drive_profile_state_stepper;

    import dpss_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 4;

    typedef struct packed {
        logic [STATE_W-1:0] target;
        logic [SW_W-1:0]    status;
    } t_drive_req;

    typedef struct packed {
        logic [CW_W-1:0] control;
        t_drive_state    state;
    } t_drive_rsp;

    typedef enum logic [2:0] {
        MV_KEEP,
        MV_SHUTDOWN,
        MV_SWITCH_ON,
        MV_DIS_VOLTAGE,
        MV_QUICK_STOP,
        MV_ENABLE_OP,
        MV_FAULT_RESET
    } t_move;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_data  = 1'b0;
    logic                   cfg_ready;
    logic                   in_valid  = 1'b0;
    logic [IN_TDATA_W-1:0]  in_data   = '0;
    logic                   in_ready;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] out_data;

    t_drive_req      status_q [$];
    t_drive_rsp      drive_out_q [$];
    t_drive_req      offered;
    logic [CW_W-1:0] held_cw     = '0;
    bit              skip_cfg    = 1'b0;
    int              src_idle    = 0;
    int              rx_stall    = 0;
    bit              rx_hold     = 1'b0;
    bit              pressure_go = 1'b0;
    int              fail_cnt    = 0;
    int              cycle_cnt   = 0;

    drive_profile_state_stepper u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    always #5 clk = ~clk;

    function automatic t_drive_state decode_status(input logic [SW_W-1:0] sw);
        logic [7:0] lo;
        lo = sw[7:0];
        if ((lo & SW_MASK_A) == SW_NOTREADY)   return ST_NOTREADY;
        if ((lo & SW_MASK_A) == SW_DISABLED)   return ST_DISABLED;
        if ((lo & SW_MASK_A) == SW_FAULTREACT) return ST_FAULTREACT;
        if ((lo & SW_MASK_A) == SW_FAULT)      return ST_FAULT;
        if ((lo & SW_MASK_B) == SW_READY)      return ST_READY;
        if ((lo & SW_MASK_B) == SW_SWITCHEDON) return ST_SWITCHEDON;
        if ((lo & SW_MASK_B) == SW_OPENABLED)  return ST_OPENABLED;
        if ((lo & SW_MASK_B) == SW_QUICKSTOP)  return ST_QUICKSTOP;
        return ST_NOTREADY;
    endfunction

    // Step the held controlword one transition toward the target.
    function automatic t_drive_rsp advance_controlword(input t_drive_req r);
        t_drive_state cur;
        t_drive_state tgt;
        t_move        mv;
        logic         chain;
        t_drive_rsp   rsp;
        cur   = decode_status(r.status);
        chain = (cur == ST_DISABLED) || (cur == ST_READY) ||
                (cur == ST_SWITCHEDON) || (cur == ST_OPENABLED);
        if (r.target >= 3'(ST_DISABLED) && r.target <= 3'(ST_OPENABLED)) begin
            tgt = t_drive_state'(r.target);
        end else begin
            tgt = ST_DISABLED;
        end
        mv = MV_KEEP;
        if (cur == ST_FAULT) begin
            mv = MV_FAULT_RESET;
        end else if (chain && cur < tgt) begin
            if (cur == ST_DISABLED) mv = MV_SHUTDOWN;
            else if (cur == ST_READY) mv = MV_SWITCH_ON;
            else mv = MV_ENABLE_OP;
        end else if (chain && cur > tgt) begin
            if (cur == ST_OPENABLED) begin
                if (!skip_cfg) mv = MV_QUICK_STOP;
                else if (tgt == ST_SWITCHEDON) mv = MV_SWITCH_ON;
                else if (tgt == ST_READY) mv = MV_SHUTDOWN;
                else mv = MV_DIS_VOLTAGE;
            end else if (cur == ST_SWITCHEDON) begin
                if (skip_cfg && tgt == ST_DISABLED) mv = MV_DIS_VOLTAGE;
                else mv = MV_SHUTDOWN;
            end else begin
                mv = MV_DIS_VOLTAGE;
            end
        end else if (skip_cfg && cur == ST_QUICKSTOP && tgt == ST_DISABLED) begin
            mv = MV_DIS_VOLTAGE;
        end
        case (mv)
            MV_SHUTDOWN: begin
                held_cw = (held_cw & ~(CW_FAULT_RST | CW_SWITCH_ON)) | CW_QUICK_STOP
                          | CW_EN_VOLTAGE;
            end
            MV_SWITCH_ON: begin
                held_cw = (held_cw & ~(CW_FAULT_RST | CW_EN_OP)) | CW_QUICK_STOP
                          | CW_EN_VOLTAGE | CW_SWITCH_ON;
            end
            MV_DIS_VOLTAGE: held_cw = held_cw & ~(CW_FAULT_RST | CW_EN_VOLTAGE);
            MV_QUICK_STOP: begin
                held_cw = (held_cw & ~(CW_FAULT_RST | CW_QUICK_STOP)) | CW_EN_VOLTAGE;
            end
            MV_ENABLE_OP: begin
                held_cw = (held_cw & ~CW_FAULT_RST) | CW_EN_OP | CW_QUICK_STOP
                          | CW_EN_VOLTAGE | CW_SWITCH_ON;
            end
            MV_FAULT_RESET: held_cw = held_cw | CW_FAULT_RST;
            default: ;
        endcase
        rsp.control = held_cw;
        rsp.state   = cur;
        return rsp;
    endfunction

    // Random statusword that decodes to the given state.
    function automatic logic [SW_W-1:0] make_status(input t_drive_state s);
        logic [SW_W-1:0] sw;
        logic [7:0]      mask;
        logic [7:0]      code;
        sw   = SW_W'($urandom);
        mask = SW_MASK_A;
        case (s)
            ST_NOTREADY:   code = SW_NOTREADY;
            ST_DISABLED:   code = SW_DISABLED;
            ST_FAULTREACT: code = SW_FAULTREACT;
            ST_FAULT:      code = SW_FAULT;
            ST_READY: begin
                mask = SW_MASK_B;
                code = SW_READY;
            end
            ST_SWITCHEDON: begin
                mask = SW_MASK_B;
                code = SW_SWITCHEDON;
            end
            ST_OPENABLED: begin
                mask = SW_MASK_B;
                code = SW_OPENABLED;
            end
            default: begin
                mask = SW_MASK_B;
                code = SW_QUICKSTOP;
            end
        endcase
        sw[7:0] = (sw[7:0] & ~mask) | code;
        return sw;
    endfunction

    task automatic push_req(input logic [SW_W-1:0] sw, input int tgt);
        t_drive_req r;
        r.status = sw;
        r.target = STATE_W'(tgt);
        status_q.push_back(r);
    endtask

    task automatic push_random(input int n);
        t_drive_state s;
        int           tgt;
        repeat (n) begin
            // Mostly decodable statuswords, leaning on the chain states.
            if ($urandom_range(99) < 50) s = t_drive_state'($urandom_range(4, 1));
            else s = t_drive_state'($urandom_range(7, 0));
            if ($urandom_range(99) < 80) tgt = $urandom_range(4, 1);
            else tgt = $urandom_range(7, 0);
            if ($urandom_range(99) < 15) push_req(SW_W'($urandom), tgt);
            else push_req(make_status(s), tgt);
        end
    endtask

    task automatic write_skip(input bit v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        skip_cfg = v;
    endtask

    task automatic drain();
        while (status_q.size() != 0 || in_valid || drive_out_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Input side: predict on each accepted beat, then offer the next one.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                drive_out_q.push_back(advance_controlword(offered));
            end
            if (!in_valid || in_ready) begin
                if (status_q.size() != 0 && $urandom_range(99) >= src_idle) begin
                    offered = status_q.pop_front();
                    in_data  <= {{(IN_TDATA_W - STATE_W - SW_W){1'b0}},
                                 offered.target, offered.status};
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each result beat against the oldest prediction.
    always @(posedge clk) begin
        t_drive_rsp want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (drive_out_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", out_data);
                    fail_cnt++;
                end else begin
                    want = drive_out_q.pop_front();
                    if (out_data[CW_W-1:0] !== want.control) begin
                        $error("control_word mismatch: expected %h, got %h",
                               want.control, out_data[CW_W-1:0]);
                        fail_cnt++;
                    end
                    if (out_data[CW_W+STATE_W-1:CW_W] !== want.state) begin
                        $error("drive_state mismatch: expected %0d, got %0d",
                               want.state, out_data[CW_W+STATE_W-1:CW_W]);
                        fail_cnt++;
                    end
                end
            end
            out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall);
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up the input.
    initial begin
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial begin
        int p;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_skip(1'b0);
        push_req(16'h0000, 0);
        push_req(16'hFFFF, 7);
        push_req(make_status(ST_FAULT), 4);
        push_req(make_status(ST_DISABLED), 2);
        push_req(make_status(ST_READY), 3);
        push_req(make_status(ST_SWITCHEDON), 4);
        push_req(make_status(ST_OPENABLED), 4);
        push_req(make_status(ST_OPENABLED), 3);
        push_req(make_status(ST_QUICKSTOP), 1);
        push_req(make_status(ST_FAULTREACT), 1);
        push_req(make_status(ST_SWITCHEDON), 1);
        push_req(make_status(ST_READY), 0);
        push_req(make_status(ST_DISABLED), 5);
        push_req(make_status(ST_FAULT), 6);
        push_req(make_status(ST_DISABLED), 4);
        drain();

        // Direct downward jumps and forced quick stop exit.
        write_skip(1'b1);
        push_req(make_status(ST_OPENABLED), 3);
        push_req(make_status(ST_OPENABLED), 2);
        push_req(make_status(ST_OPENABLED), 1);
        push_req(make_status(ST_OPENABLED), 7);
        push_req(make_status(ST_SWITCHEDON), 1);
        push_req(make_status(ST_SWITCHEDON), 2);
        push_req(make_status(ST_QUICKSTOP), 1);
        push_req(make_status(ST_QUICKSTOP), 3);
        push_req(make_status(ST_READY), 4);
        push_req(make_status(ST_FAULT), 0);
        drain();

        for (p = 0; p < PHASES; p++) begin
            write_skip(bit'(p[0] ^ p[2]));
            src_idle <= (p % 4 == 1) ? 65 : (p % 4 == 3) ? 10 : 0;
            rx_stall <= (p % 4 == 2) ? 65 : (p % 4 == 3) ? 10 : 0;
            if (p == 4) pressure_go = 1'b1;
            push_random(PHASE_ITEMS);
            drain();
        end

        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
